// ===== rtl/tcc_pkg.sv =====
// Shared types, codes and sizes of the triplet to compressed-column converter.
// Used by triplet_to_csc_compress; depends on nothing else.
`default_nettype none

package tcc_pkg;

    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int MAX_COLUMNS_DEF = 1024;

    localparam int OP_W     = 3;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 10;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 13;
    localparam int STATUS_W = 2;
    localparam int PTR_W    = 13;
    localparam int TOTAL_W  = 13;
    localparam int SPAN_W   = 11;
    localparam int CFG_W    = 11;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 88;

    // Wide enough to compare any count, column or position against a limit.
    localparam int CMP_W = 17;

    localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
    localparam logic [OP_W-1:0] OP_COMPRESS   = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_PTR   = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_ENTRY = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } in_data_t;

    typedef struct packed {
        logic [SPAN_W-1:0]   column_span;
        logic [TOTAL_W-1:0]  entry_total;
        logic [VALUE_W-1:0]  out_value;
        logic [ROW_W-1:0]    out_row;
        logic [PTR_W-1:0]    pointer;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [VALUE_W-1:0] value;
    } trip_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [VALUE_W-1:0] value;
    } packed_entry_t;

endpackage

`default_nettype wire

// ===== rtl/triplet_to_csc_compress.sv =====
// Top level of the sparse triplet store with compression to column order.
// Depends on tcc_pkg and tcc_ram.
`default_nettype none

// Triplets are appended to a store and a compress request sorts them into
// compressed sparse column form by counting, prefix sum and scatter. Append,
// clear and unused op codes are answered straight from the idle state; the two
// read requests pass through a read state for the registered memory read. A
// compress holds off input until it is done: the column count memory is swept
// once to clear and once for the prefix sum, and the triplet memory is walked
// once to count and once to scatter, one entry per cycle through the single
// read port of each memory.
// No clearing pass is needed after reset.
module triplet_to_csc_compress
    import tcc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_W-1:0]      cfg_wdata,   // initial_columns
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,     // row, col, value, position
    input  wire logic [OP_W-1:0]       s_tuser,     // op
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata      // status, pointer, out_row,
                                                    // out_value, entry_total,
                                                    // column_span
);

    localparam int HW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SW = $clog2(MAX_COLUMNS + 1);
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int TRIP_W = $bits(trip_t);
    localparam int PACK_W = $bits(packed_entry_t);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_CLEAR   = 3'd2;
    localparam logic [2:0] S_COUNT   = 3'd3;
    localparam logic [2:0] S_PREFIX  = 3'd4;
    localparam logic [2:0] S_FINAL   = 3'd5;
    localparam logic [2:0] S_SCATTER = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [HW-1:0]    held_reg, held_next;
    logic [SW-1:0]    span_reg, span_next;
    logic             flag_reg, flag_next;
    logic [CFG_W-1:0] init_reg;
    logic [HW-1:0]    k_reg, k_next;
    logic [SW-1:0]    j_reg, j_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic             lw_v_reg, lw_v_next;
    logic             pv_reg, pv_next;
    logic             out_valid_reg, out_valid_next;

    logic [CW-1:0]      c2_reg, c2_next;
    logic [ROW_W-1:0]   row2_reg, row2_next;
    logic [VALUE_W-1:0] val2_reg, val2_next;
    logic [CW-1:0]      lw_col_reg, lw_col_next;
    logic [HW-1:0]      lw_val_reg, lw_val_next;
    logic [SW-1:0]      pj_reg, pj_next;
    logic [HW-1:0]      total_reg, total_next;
    logic               rd_entry_reg, rd_entry_next;
    logic               rd_ok_reg, rd_ok_next;
    result_t            out_reg, out_next;

    in_data_t      in_d;
    trip_t         trip_rd;
    packed_entry_t pk_rd;
    logic          accept;
    logic          load;
    logic          issue;
    result_t       res;
    logic [HW-1:0] cur;
    logic [HW-1:0] cur_inc;
    logic [SW-1:0] clear_span;

    logic              trip_we;
    logic [AW-1:0]     trip_waddr, trip_raddr;
    logic [TRIP_W-1:0] trip_wdata, trip_rdata;
    logic              cnt_we;
    logic [CW-1:0]     cnt_waddr, cnt_raddr;
    logic [HW-1:0]     cnt_wdata, cnt_rdata;
    logic              st_we;
    logic [SW-1:0]     st_waddr, st_raddr;
    logic [HW-1:0]     st_wdata, st_rdata;
    logic              pk_we;
    logic [AW-1:0]     pk_waddr, pk_raddr;
    logic [PACK_W-1:0] pk_wdata, pk_rdata;

    assign in_d    = in_data_t'(s_tdata[$bits(in_data_t)-1:0]);
    assign trip_rd = trip_t'(trip_rdata);
    assign pk_rd   = packed_entry_t'(pk_rdata);

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);

    assign clear_span = (CMP_W'(init_reg) > CMP_W'(MAX_COLUMNS)) ?
                        SW'(MAX_COLUMNS) : SW'(init_reg);

    // A count written in the previous cycle is not yet visible to a read
    // issued in that same cycle, so it is forwarded.
    assign cur     = (lw_v_reg && (lw_col_reg == c2_reg)) ? lw_val_reg : cnt_rdata;
    assign cur_inc = cur + HW'(1);

    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        span_next     = span_reg;
        flag_next     = flag_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        total_next    = total_reg;
        rd_entry_next = rd_entry_reg;
        rd_ok_next    = rd_ok_reg;
        v1_next       = 1'b0;
        v2_next       = 1'b0;
        pv_next       = 1'b0;
        lw_v_next     = 1'b0;
        c2_next       = CW'(trip_rd.col);
        row2_next     = trip_rd.row;
        val2_next     = trip_rd.value;
        lw_col_next   = c2_reg;
        lw_val_next   = cur_inc;
        pj_next       = j_reg;
        issue         = 1'b0;
        load          = 1'b0;
        res           = '0;

        trip_we    = 1'b0;
        trip_waddr = held_reg[AW-1:0];
        trip_wdata = {in_d.row, in_d.col, in_d.value};
        trip_raddr = k_reg[AW-1:0];
        cnt_we     = 1'b0;
        cnt_waddr  = c2_reg;
        cnt_wdata  = cur_inc;
        cnt_raddr  = CW'(trip_rd.col);
        st_we      = 1'b0;
        st_waddr   = pj_reg;
        st_wdata   = total_reg;
        st_raddr   = SW'(in_d.position);
        pk_we      = 1'b0;
        pk_waddr   = cur[AW-1:0];
        pk_wdata   = {row2_reg, val2_reg};
        pk_raddr   = AW'(in_d.position);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        OP_APPEND:
                        begin
                            load = 1'b1;
                            if (held_reg == HW'(MAX_ENTRIES))
                            begin
                                res.status = ST_FULL;
                            end
                            else if (CMP_W'(in_d.col) >= CMP_W'(MAX_COLUMNS))
                            begin
                                res.status = ST_RANGE;
                            end
                            else
                            begin
                                trip_we   = 1'b1;
                                held_next = held_reg + HW'(1);
                                flag_next = 1'b0;
                                if (CMP_W'(in_d.col) + CMP_W'(1) > CMP_W'(span_reg))
                                begin
                                    span_next = SW'(CMP_W'(in_d.col) + CMP_W'(1));
                                end
                            end
                        end
                        OP_COMPRESS:
                        begin
                            j_next     = '0;
                            state_next = S_CLEAR;
                        end
                        OP_READ_PTR:
                        begin
                            rd_entry_next = 1'b0;
                            rd_ok_next    = flag_reg &&
                                            (CMP_W'(in_d.position) <= CMP_W'(span_reg));
                            state_next    = S_READ;
                        end
                        OP_READ_ENTRY:
                        begin
                            rd_entry_next = 1'b1;
                            rd_ok_next    = flag_reg &&
                                            (CMP_W'(in_d.position) < CMP_W'(held_reg));
                            state_next    = S_READ;
                        end
                        OP_CLEAR:
                        begin
                            load      = 1'b1;
                            held_next = '0;
                            span_next = clear_span;
                            flag_next = 1'b0;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                load       = 1'b1;
                state_next = S_IDLE;
                if (!rd_ok_reg)
                begin
                    res.status = ST_RANGE;
                end
                else if (rd_entry_reg)
                begin
                    res.out_row   = pk_rd.row;
                    res.out_value = pk_rd.value;
                end
                else
                begin
                    res.pointer = PTR_W'(st_rdata);
                end
            end
            S_CLEAR:
            begin
                if (j_reg < span_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = j_reg[CW-1:0];
                    cnt_wdata = '0;
                    j_next    = j_reg + SW'(1);
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_COUNT;
                end
            end
            S_COUNT, S_SCATTER:
            begin
                issue   = (k_reg < held_reg);
                v1_next = issue;
                v2_next = v1_reg;
                if (issue)
                begin
                    k_next = k_reg + HW'(1);
                end
                if (v2_reg)
                begin
                    cnt_we    = 1'b1;
                    lw_v_next = 1'b1;
                    pk_we     = (state_reg == S_SCATTER);
                end
                if (!issue && !v1_reg && !v2_reg)
                begin
                    if (state_reg == S_COUNT)
                    begin
                        j_next     = '0;
                        total_next = '0;
                        state_next = S_PREFIX;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PREFIX:
            begin
                issue     = (j_reg < span_reg);
                cnt_raddr = j_reg[CW-1:0];
                pv_next   = issue;
                if (issue)
                begin
                    j_next = j_reg + SW'(1);
                end
                if (pv_reg)
                begin
                    st_we      = 1'b1;
                    cnt_we     = 1'b1;
                    cnt_waddr  = pj_reg[CW-1:0];
                    cnt_wdata  = total_reg;
                    total_next = total_reg + cnt_rdata;
                end
                if (!issue && !pv_reg)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                st_we      = 1'b1;
                st_waddr   = span_reg;
                k_next     = '0;
                state_next = S_SCATTER;
            end
            S_DONE:
            begin
                load       = 1'b1;
                flag_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.entry_total = TOTAL_W'(held_next);
        res.column_span = SPAN_W'(span_next);

        out_next       = load ? res : out_reg;
        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            span_reg      <= '0;
            flag_reg      <= 1'b0;
            init_reg      <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            lw_v_reg      <= 1'b0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            span_reg      <= span_next;
            flag_reg      <= flag_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            lw_v_reg      <= lw_v_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                init_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c2_reg       <= c2_next;
        row2_reg     <= row2_next;
        val2_reg     <= val2_next;
        lw_col_reg   <= lw_col_next;
        lw_val_reg   <= lw_val_next;
        pj_reg       <= pj_next;
        total_reg    <= total_next;
        rd_entry_reg <= rd_entry_next;
        rd_ok_reg    <= rd_ok_next;
        out_reg      <= out_next;
    end

    tcc_ram #(
        .WIDTH (TRIP_W),
        .DEPTH (MAX_ENTRIES)
    ) u_trip_ram (
        .clk   (clk),
        .we    (trip_we),
        .waddr (trip_waddr),
        .wdata (trip_wdata),
        .raddr (trip_raddr),
        .rdata (trip_rdata)
    );

    tcc_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_COLUMNS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    tcc_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_COLUMNS + 1)
    ) u_start_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    tcc_ram #(
        .WIDTH (PACK_W),
        .DEPTH (MAX_ENTRIES)
    ) u_packed_ram (
        .clk   (clk),
        .we    (pk_we),
        .waddr (pk_waddr),
        .wdata (pk_wdata),
        .raddr (pk_raddr),
        .rdata (pk_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/tcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for every store of triplet_to_csc_compress.
`default_nettype none

module tcc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== tb/tb_triplet_to_csc_compress.sv =====
// Self-checking testbench for triplet_to_csc_compress: appends, compress, reads and clears
// checked against an in-bench column-sort predictor under bursty input and stalled output.
// Depends on tcc_pkg and the RTL of triplet_to_csc_compress.
`timescale 1ns / 100ps

module tb_triplet_to_csc_compress;
    import tcc_pkg::*;

    localparam int MAXE = MAX_ENTRIES_DEF;
    localparam int MAXC = MAX_COLUMNS_DEF;
    localparam int IDLE_LIMIT = 60000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES = 600;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] op;
        in_data_t        data;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    stim_t pending_items[$];
    result_t awaited_results[$];
    int errors = 0;
    int queued_count = 0;

    logic [ROW_W-1:0]   trip_row [MAXE];
    logic [COL_W-1:0]   trip_col [MAXE];
    logic [VALUE_W-1:0] trip_val [MAXE];
    logic [ROW_W-1:0]   csc_row [MAXE];
    logic [VALUE_W-1:0] csc_val [MAXE];
    logic [PTR_W-1:0]   col_start [MAXC+1];
    int                 col_fill [MAXC];
    int                 held_m = 0;
    int                 span_m = 0;
    bit                 csc_ready = 1'b0;
    logic [CFG_W-1:0]   init_cols_m = '0;

    int gen_span;
    int gen_held;

    triplet_to_csc_compress dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int clear_span_of(input logic [CFG_W-1:0] v);
        return (int'(v) > MAXC) ? MAXC : int'(v);
    endfunction

    function automatic result_t csc_result(input logic [OP_W-1:0] op, input in_data_t d);
        result_t r;
        int k;
        int j;
        int total;
        int cnt;
        int dst;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_APPEND:
            begin
                if (held_m >= MAXE)
                begin
                    r.status = ST_FULL;
                end
                else if (int'(d.col) >= MAXC)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    trip_row[held_m] = d.row;
                    trip_col[held_m] = d.col;
                    trip_val[held_m] = d.value;
                    held_m++;
                    if (int'(d.col) + 1 > span_m)
                        span_m = int'(d.col) + 1;
                    csc_ready = 1'b0;
                end
            end
            OP_COMPRESS:
            begin
                for (j = 0; j < MAXC; j++)
                    col_fill[j] = 0;
                for (k = 0; k < held_m; k++)
                    col_fill[trip_col[k]]++;
                total = 0;
                for (j = 0; j < span_m && j < MAXC; j++)
                begin
                    cnt = col_fill[j];
                    col_start[j] = PTR_W'(total);
                    col_fill[j] = total;
                    total += cnt;
                end
                col_start[j] = PTR_W'(total);
                for (k = 0; k < held_m; k++)
                begin
                    dst = col_fill[trip_col[k]];
                    col_fill[trip_col[k]]++;
                    if (dst < MAXE)
                    begin
                        csc_row[dst] = trip_row[k];
                        csc_val[dst] = trip_val[k];
                    end
                end
                csc_ready = 1'b1;
            end
            OP_READ_PTR:
            begin
                if (!csc_ready || int'(d.position) > span_m || int'(d.position) > MAXC)
                    r.status = ST_RANGE;
                else
                    r.pointer = col_start[d.position];
            end
            OP_READ_ENTRY:
            begin
                if (!csc_ready || int'(d.position) >= held_m || int'(d.position) >= MAXE)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.out_row = csc_row[d.position];
                    r.out_value = csc_val[d.position];
                end
            end
            OP_CLEAR:
            begin
                held_m = 0;
                span_m = clear_span_of(init_cols_m);
                csc_ready = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.entry_total = TOTAL_W'(held_m);
        r.column_span = SPAN_W'(span_m);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Driver: bursts of transfers separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin : drive
        stim_t nxt;
        logic give;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            give = 1'b0;
            nxt = '0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_items.size() > 0)
            begin
                nxt = pending_items.pop_front();
                give = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    case ($urandom_range(0, 15))
                        0:             gap_left = $urandom_range(20, 40);
                        1, 2, 3, 4, 5: gap_left = 0;
                        default:       gap_left = $urandom_range(1, 5);
                    endcase
                end
            end
            s_tvalid <= give;
            if (give)
            begin
                s_tdata <= IN_DATA_W'(nxt.data);
                s_tuser <= nxt.op;
            end
        end
    end

    // Receiver: changing stall patterns plus one long hold while input keeps coming.
    int rx_done = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int rx_mode = 0;
    int mode_left = 0;
    logic [1:0] pattern_cnt = '0;

    always @(posedge clk)
    begin : receive
        logic rdy;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            rdy = 1'b1;
            pattern_cnt <= pattern_cnt + 2'd1;
            if (m_tvalid && m_tready)
                rx_done++;
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (!hold_done && rx_done >= 300 && pending_items.size() > 50)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end
                else
                begin
                    mode_left--;
                end
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 9) != 0);
                    default: rdy = (pattern_cnt != 2'd3);
                endcase
            end
            m_tready <= rdy;
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge clk)
    begin : watch
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                awaited_results.push_back(csc_result(s_tuser,
                    in_data_t'(s_tdata[$bits(in_data_t)-1:0])));
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("pointer", 32'(want.pointer), 32'(got.pointer));
                    check_field("out_row", 32'(want.out_row), 32'(got.out_row));
                    check_field("out_value", want.out_value, got.out_value);
                    check_field("entry_total", 32'(want.entry_total), 32'(got.entry_total));
                    check_field("column_span", 32'(want.column_span), 32'(got.column_span));
                end
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                              input logic [COL_W-1:0] col, input logic [VALUE_W-1:0] value,
                              input logic [POS_W-1:0] pos);
        stim_t it;
        it.op = op;
        it.data.row = row;
        it.data.col = col;
        it.data.value = value;
        it.data.position = pos;
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic queue_noise_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos);
        queue_item(op, ROW_W'($urandom), COL_W'($urandom), $urandom, pos);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_init_cols(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        init_cols_m = v;
        repeat (2) @(negedge clk);
    endtask

    task automatic queue_append(input logic [COL_W-1:0] col);
        queue_item(OP_APPEND, ROW_W'($urandom), col, $urandom, POS_W'($urandom));
        gen_held++;
        if (int'(col) + 1 > gen_span)
            gen_span = int'(col) + 1;
    endtask

    // One load, compress and read-back run with random content and some broken steps.
    task automatic random_sequence();
        int n;
        int k;
        int cmax;
        int reads;
        queue_noise_op(OP_CLEAR, POS_W'($urandom));
        gen_span = clear_span_of(init_cols_m);
        gen_held = 0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
        cmax = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 15);
        for (k = 0; k < n; k++)
        begin
            queue_append(COL_W'($urandom_range(0, cmax)));
            if ($urandom_range(0, 19) == 0)
                queue_noise_op(OP_W'($urandom_range(int'(OP_COMPRESS), int'(OP_SPARE_HI))),
                               POS_W'($urandom_range(0, gen_held)));
        end
        if ($urandom_range(0, 7) != 0)
            queue_noise_op(OP_COMPRESS, POS_W'($urandom));
        reads = $urandom_range(2, 12);
        for (k = 0; k < reads; k++)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: queue_noise_op(OP_READ_PTR, POS_W'($urandom_range(0, gen_span + 1)));
                4, 5, 6, 7: queue_noise_op(OP_READ_ENTRY, POS_W'($urandom_range(0, gen_held)));
                8:  queue_noise_op($urandom_range(0, 1) ? OP_READ_PTR : OP_READ_ENTRY,
                                   POS_W'($urandom));
                9:  queue_noise_op(OP_W'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI))),
                                   POS_W'($urandom));
                10: queue_append(COL_W'($urandom_range(0, cmax)));
                default: queue_noise_op(OP_COMPRESS, POS_W'($urandom));
            endcase
        end
    endtask

    initial
    begin : stimulus
        int ph;
        int k;
        int quota;
        logic [CFG_W-1:0] setting;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reads before compress, empty compress, extreme fields, stale reads.
        queue_item(OP_READ_PTR, '0, '0, '0, '0);
        queue_item(OP_READ_ENTRY, '1, '1, '1, '1);
        queue_item(OP_SPARE_LO, '1, '1, '1, '1);
        queue_item(OP_SPARE_HI, '0, '0, '0, '0);
        queue_item(OP_COMPRESS, '0, '0, '0, '0);
        queue_item(OP_READ_PTR, '0, '0, '0, '0);
        queue_item(OP_READ_PTR, '0, '0, '0, POS_W'(1));
        queue_item(OP_READ_ENTRY, '0, '0, '0, '0);
        queue_item(OP_APPEND, '1, '1, '1, '1);
        queue_item(OP_APPEND, '0, '0, '0, '0);
        queue_item(OP_APPEND, ROW_W'(5), '1, 32'h1234_5678, '0);
        queue_item(OP_COMPRESS, '0, '0, '0, '0);
        queue_item(OP_READ_PTR, '0, '0, '0, '0);
        queue_item(OP_READ_PTR, '0, '0, '0, POS_W'(1023));
        queue_item(OP_READ_PTR, '0, '0, '0, POS_W'(1024));
        queue_item(OP_READ_PTR, '0, '0, '0, POS_W'(1025));
        queue_item(OP_READ_PTR, '0, '0, '0, '1);
        queue_item(OP_READ_ENTRY, '0, '0, '0, POS_W'(0));
        queue_item(OP_READ_ENTRY, '0, '0, '0, POS_W'(1));
        queue_item(OP_READ_ENTRY, '0, '0, '0, POS_W'(2));
        queue_item(OP_READ_ENTRY, '0, '0, '0, POS_W'(3));
        queue_item(OP_APPEND, ROW_W'(7), COL_W'(2), 32'hA5A5_5A5A, '0);
        queue_item(OP_READ_PTR, '0, '0, '0, '0);
        queue_item(OP_READ_ENTRY, '0, '0, '0, '0);
        queue_item(OP_CLEAR, '1, '1, '1, '1);
        wait_drained();

        quota = RANDOM_ITEMS / 7;
        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:       setting = '1;
                1:       setting = CFG_W'(MAXC);
                2:       setting = '0;
                3:       setting = CFG_W'(1);
                4:       setting = CFG_W'(MAXC - 1);
                default: setting = CFG_W'($urandom_range(0, 40));
            endcase
            write_init_cols(setting);
            queued_count = 0;
            while (queued_count < quota)
                random_sequence();
            wait_drained();
        end

        // Full store: fill every entry, reject more, then compress and read both ends.
        write_init_cols(CFG_W'($urandom_range(0, 63)));
        queue_noise_op(OP_CLEAR, '0);
        for (k = 0; k < MAXE; k++)
            queue_item(OP_APPEND, ROW_W'($urandom), COL_W'($urandom_range(0, 63)), $urandom,
                       POS_W'($urandom));
        queue_noise_op(OP_APPEND, '0);
        queue_noise_op(OP_COMPRESS, '0);
        queue_noise_op(OP_APPEND, '1);
        queue_noise_op(OP_READ_ENTRY, POS_W'(MAXE - 1));
        queue_noise_op(OP_READ_ENTRY, POS_W'(MAXE));
        queue_noise_op(OP_READ_ENTRY, '0);
        queue_noise_op(OP_READ_PTR, POS_W'(64));
        for (k = 0; k < 8; k++)
        begin
            queue_noise_op(OP_READ_ENTRY, POS_W'($urandom_range(0, MAXE - 1)));
            queue_noise_op(OP_READ_PTR, POS_W'($urandom_range(0, 65)));
        end
        queue_noise_op(OP_CLEAR, '0);
        wait_drained();

        repeat (20) @(posedge clk);
        if (errors == 0 && awaited_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
